// ===== rtl/core/rbdeq_pkg.sv =====
// Shared types and codes for the ring buffer deque.
package rbdeq_pkg;

  localparam int CAP_W = 10;
  localparam logic [CAP_W-1:0] CAP_RESET = 10'd1023;

  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_PEEK       = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd4;

  localparam int ST_W = 2;
  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  // Per-item status that travels from the pointer unit to the output stage.
  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [CAP_W-1:0] count;
    logic             is_empty;
    logic             is_full;
  } flags_t;

endpackage

// ===== rtl/core/ring_buffer_double_ended_queue.sv =====
// Ring buffer deque: pushes and pops at either end of a ring held in one memory.
// One item is taken per clock cycle when the output side keeps up; its result
// passes through the read stage, which holds it for the registered read of the
// entry memory that supplies the front and back values, and the output register.
// Pointers are updated and any push written at the accepting edge, and the new end
// entries are read at that same edge, with the pushed value forwarded where it
// lands on a slot being read. The store is not cleared after reset; an entry's
// value is only used after a push has written it. Writing the capacity empties
// the deque and must only happen while no item is in flight.
module ring_buffer_double_ended_queue #(
  parameter int SLOTS = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [rbdeq_pkg::CAP_W-1:0] cfg_wr_data,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // push_value, zero padded to whole bytes
  input  logic [((DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // operation
  input  logic [rbdeq_pkg::OP_W-1:0]  s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // status, front_value, back_value, element_count, is_empty, is_full
  output logic [((2*DATA_WIDTH+14+7)/8)*8-1:0] m_axis_tdata
);
  import rbdeq_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam int OUT_W = 2 * DATA_WIDTH + 14;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

  logic                  accept;
  logic                  advance;
  flags_t                flags;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr_front;
  logic [AW-1:0]         rd_addr_back;
  logic [DATA_WIDTH-1:0] push_value;
  logic [DATA_WIDTH-1:0] rd_front;
  logic [DATA_WIDTH-1:0] rd_back;

  logic                  s1_valid;
  flags_t                s1_flags;
  logic                  s1_fwd_front;
  logic                  s1_fwd_back;
  logic [DATA_WIDTH-1:0] s1_push;

  logic                  out_valid;
  flags_t                out_flags;
  logic [DATA_WIDTH-1:0] out_front;
  logic [DATA_WIDTH-1:0] out_back;

  assign push_value = s_axis_tdata[DATA_WIDTH-1:0];
  assign advance = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || advance;
  assign accept = s_axis_tvalid && s_axis_tready;

  rbdeq_ptr #(
    .SLOTS(SLOTS)
  ) u_ptr (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .accept       (accept),
    .operation    (s_axis_tuser),
    .flags        (flags),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .rd_addr_front(rd_addr_front),
    .rd_addr_back (rd_addr_back)
  );

  rbdeq_ram #(
    .DEPTH(SLOTS),
    .AW   (AW),
    .DW   (DATA_WIDTH)
  ) u_ram (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (push_value),
    .rd_en    (accept),
    .rd_addr_a(rd_addr_front),
    .rd_addr_b(rd_addr_back),
    .rd_data_a(rd_front),
    .rd_data_b(rd_back)
  );

  // Read stage: waits for the memory data while holding the item's status.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flags     <= flags;
      s1_push      <= push_value;
      s1_fwd_front <= wr_en && (wr_addr == rd_addr_front);
      s1_fwd_back  <= wr_en && (wr_addr == rd_addr_back);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_flags <= s1_flags;
      if (s1_flags.is_empty) begin
        out_front <= '0;
        out_back  <= '0;
      end else begin
        out_front <= s1_fwd_front ? s1_push : rd_front;
        out_back  <= s1_fwd_back ? s1_push : rd_back;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = OUT_TW'({out_flags.is_full, out_flags.is_empty, out_flags.count,
                                 out_back, out_front, out_flags.status});

  // A result waiting in the read stage is never dropped or altered.
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_flags)))
    else $error("read stage lost or changed a pending result");

  // A rejected push only happens on a full deque.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_flags.status == ST_FULL)) |-> out_flags.is_full)
    else $error("push rejected although deque not full");

  // A rejected pop only happens on an empty deque.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_flags.status == ST_EMPTY)) |-> out_flags.is_empty)
    else $error("pop rejected although deque not empty");

  // Empty flag, count and end values agree.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_flags.is_empty) |->
      ((out_flags.count == '0) && (out_front == '0) && (out_back == '0)))
    else $error("empty deque reports elements or values");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_flags.is_empty) |-> (out_flags.count != '0))
    else $error("non-empty deque reports zero count");

endmodule

// ===== rtl/core/rbdeq_ram.sv =====
// Entry store: one write port and two registered read ports.
module rbdeq_ram #(
  parameter int DEPTH = 1024,
  parameter int AW = 10,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr_a,
  input  logic [AW-1:0] rd_addr_b,
  output logic [DW-1:0] rd_data_a,
  output logic [DW-1:0] rd_data_b
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// ===== rtl/core/rbdeq_ptr.sv =====
// Head and tail pointers, capacity register and per-item status logic.
module rbdeq_ptr #(
  parameter int SLOTS = 1024,
  localparam int AW = $clog2(SLOTS)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [rbdeq_pkg::CAP_W-1:0] cfg_wr_data,
  input  logic                       accept,
  input  logic [rbdeq_pkg::OP_W-1:0] operation,
  output rbdeq_pkg::flags_t          flags,
  output logic                       wr_en,
  output logic [AW-1:0]              wr_addr,
  output logic [AW-1:0]              rd_addr_front,
  output logic [AW-1:0]              rd_addr_back
);
  import rbdeq_pkg::*;

  localparam int LW = (AW > CAP_W) ? AW : CAP_W;

  logic [CAP_W-1:0] capacity;
  logic [AW-1:0]    head;
  logic [AW-1:0]    tail;
  logic [AW-1:0]    head_next;
  logic [AW-1:0]    tail_next;
  logic [AW-1:0]    last;
  logic [LW-1:0]    cap_ext;
  logic [LW:0]      cnt_w;
  logic             empty_now;
  logic             full_now;
  logic [ST_W-1:0]  status;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i,
                                              input logic [AW-1:0] lst);
    return (i == lst) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i,
                                              input logic [AW-1:0] lst);
    return (i == '0) ? lst : i - AW'(1);
  endfunction

  // Highest ring index: the capacity, saturated to the highest slot of the store.
  always_comb begin
    cap_ext = LW'(capacity);
    last = (cap_ext > LW'(SLOTS - 1)) ? AW'(SLOTS - 1) : cap_ext[AW-1:0];
  end

  always_comb begin
    empty_now = (head == tail);
    full_now  = (ring_next(tail, last) == head);
    head_next = head;
    tail_next = tail;
    status    = ST_DONE;
    wr_en     = 1'b0;
    wr_addr   = tail;
    case (operation)
      OP_PUSH_FRONT: begin
        if (full_now) begin
          status = ST_FULL;
        end else begin
          head_next = ring_prev(head, last);
          wr_en     = accept;
          wr_addr   = ring_prev(head, last);
        end
      end
      OP_PUSH_BACK: begin
        if (full_now) begin
          status = ST_FULL;
        end else begin
          tail_next = ring_next(tail, last);
          wr_en     = accept;
          wr_addr   = tail;
        end
      end
      OP_POP_FRONT: begin
        if (empty_now) begin
          status = ST_EMPTY;
        end else begin
          head_next = ring_next(head, last);
        end
      end
      OP_POP_BACK: begin
        if (empty_now) begin
          status = ST_EMPTY;
        end else begin
          tail_next = ring_prev(tail, last);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (head_next <= tail_next) begin
      cnt_w = (LW+1)'(tail_next) - (LW+1)'(head_next);
    end else begin
      cnt_w = (LW+1)'(tail_next) + (LW+1)'(last) + (LW+1)'(1) - (LW+1)'(head_next);
    end
    flags.status   = status;
    flags.count    = cnt_w[CAP_W-1:0];
    flags.is_empty = (head_next == tail_next);
    flags.is_full  = (ring_next(tail_next, last) == head_next);
    rd_addr_front  = head_next;
    rd_addr_back   = ring_prev(tail_next, last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      head     <= '0;
      tail     <= '0;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
      head     <= '0;
      tail     <= '0;
    end else if (accept) begin
      head <= head_next;
      tail <= tail_next;
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the ring buffer deque: a directed table, then randomised phases.
`timescale 1ns / 1ps

module testbench;
  import rbdeq_pkg::*;

  localparam int DW = 32;
  localparam int RING_MAX = 1024;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PEND_DEPTH = 16;

  // Operation codes the block does not define; they must behave as a peek.
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [DW-1:0]    front;
    logic [DW-1:0]    back;
    logic [CAP_W-1:0] count;
    logic             is_empty;
    logic             is_full;
  } deq_result_t;

  typedef struct packed {
    bit               is_cfg;
    bit               pinned;
    logic [OP_W-1:0]  op;
    logic [DW-1:0]    value;
    deq_result_t      want;
  } step_row_t;

  typedef enum {MODE_FILL, MODE_MIX, MODE_DRAIN} traffic_mode_t;

  localparam deq_result_t PREDICTED    = '0;
  localparam deq_result_t EMPTY_VIEW   = '{ST_DONE, 32'h0, 32'h0, 10'd0, 1'b1, 1'b0};
  localparam deq_result_t POP_ON_EMPTY = '{ST_EMPTY, 32'h0, 32'h0, 10'd0, 1'b1, 1'b0};

  // For configuration rows the value column carries the new capacity.
  localparam step_row_t SCRIPT [27] = '{
    '{1'b0, 1'b1, OP_PEEK,       32'h0,        EMPTY_VIEW},
    '{1'b0, 1'b1, OP_POP_FRONT,  32'h0,        POP_ON_EMPTY},
    '{1'b0, 1'b1, OP_POP_BACK,   32'h0,        POP_ON_EMPTY},
    '{1'b0, 1'b0, OP_PUSH_BACK,  32'h0,        PREDICTED},
    '{1'b0, 1'b0, OP_PUSH_FRONT, 32'hFFFFFFFF, PREDICTED},
    '{1'b0, 1'b0, OP_PUSH_BACK,  32'hA5A5A5A5, PREDICTED},
    '{1'b0, 1'b0, OP_SPARE_A,    32'h12345678, PREDICTED},
    '{1'b0, 1'b0, OP_SPARE_B,    32'h0,        PREDICTED},
    '{1'b0, 1'b0, OP_SPARE_C,    32'hFFFFFFFF, PREDICTED},
    '{1'b0, 1'b0, OP_POP_FRONT,  32'h0,        PREDICTED},
    '{1'b0, 1'b0, OP_POP_BACK,   32'h0,        PREDICTED},
    '{1'b0, 1'b0, OP_POP_BACK,   32'h0,        PREDICTED},
    '{1'b0, 1'b1, OP_POP_FRONT,  32'h0,        POP_ON_EMPTY},
    '{1'b1, 1'b0, OP_PEEK,       32'd1,        PREDICTED},
    '{1'b0, 1'b0, OP_PUSH_FRONT, 32'h80000001, PREDICTED},
    '{1'b0, 1'b1, OP_PUSH_BACK,  32'h1,
      '{ST_FULL, 32'h80000001, 32'h80000001, 10'd1, 1'b0, 1'b1}},
    '{1'b0, 1'b1, OP_PUSH_FRONT, 32'h2,
      '{ST_FULL, 32'h80000001, 32'h80000001, 10'd1, 1'b0, 1'b1}},
    '{1'b0, 1'b0, OP_POP_BACK,   32'h0,        PREDICTED},
    '{1'b0, 1'b0, OP_PUSH_BACK,  32'h5A5A5A5A, PREDICTED},
    '{1'b0, 1'b0, OP_PUSH_FRONT, 32'h3,        PREDICTED},
    // The capacity write lands while the deque still holds an element.
    '{1'b1, 1'b0, OP_PEEK,       32'd2,        PREDICTED},
    '{1'b0, 1'b1, OP_PEEK,       32'h0,        EMPTY_VIEW},
    '{1'b0, 1'b0, OP_PUSH_BACK,  32'd7,        PREDICTED},
    '{1'b0, 1'b0, OP_PUSH_BACK,  32'd8,        PREDICTED},
    '{1'b0, 1'b1, OP_PUSH_FRONT, 32'd9,
      '{ST_FULL, 32'd7, 32'd8, 10'd2, 1'b0, 1'b1}},
    '{1'b0, 1'b0, OP_POP_FRONT,  32'h0,        PREDICTED},
    '{1'b0, 1'b0, OP_POP_FRONT,  32'h0,        PREDICTED}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CAP_W-1:0] cfg_wr_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // push_value
  logic [DW-1:0] s_axis_tdata = '0;
  // operation
  logic [OP_W-1:0] s_axis_tuser = OP_PEEK;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // status, front_value, back_value, element_count, is_empty, is_full
  logic [79:0] m_axis_tdata;

  // Predictor state.
  logic [DW-1:0] dq_store [0:RING_MAX-1];
  int dq_head = 0;
  int dq_tail = 0;
  logic [CAP_W-1:0] dq_cap = CAP_RESET;

  // Results still owed by the block, oldest at the read count.
  deq_result_t pend_results [PEND_DEPTH];
  int pend_wr = 0;
  int pend_rd = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int stall_left = 0;
  bit src_idling = 1'b0;
  bit sink_idling = 1'b0;

  ring_buffer_double_ended_queue u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int wrap_next(input int idx, input int len);
    return (idx + 1 >= len) ? 0 : idx + 1;
  endfunction

  function automatic int wrap_prev(input int idx, input int len);
    return (idx == 0) ? len - 1 : idx - 1;
  endfunction

  function automatic int ring_len();
    return int'(dq_cap) + 1;
  endfunction

  function automatic bit deque_full();
    return wrap_next(dq_tail, ring_len()) == dq_head;
  endfunction

  // Applies one item to the predictor and returns the result it reports.
  function automatic deq_result_t deque_step(input logic [OP_W-1:0] op,
                                             input logic [DW-1:0] value);
    int len;
    bit was_empty;
    bit was_full;
    deq_result_t r;
    len = ring_len();
    was_empty = (dq_head == dq_tail);
    was_full = deque_full();
    r = '0;
    r.status = ST_DONE;
    case (op)
      OP_PUSH_FRONT: begin
        if (was_full) begin
          r.status = ST_FULL;
        end else begin
          dq_head = wrap_prev(dq_head, len);
          dq_store[dq_head] = value;
        end
      end
      OP_PUSH_BACK: begin
        if (was_full) begin
          r.status = ST_FULL;
        end else begin
          dq_store[dq_tail] = value;
          dq_tail = wrap_next(dq_tail, len);
        end
      end
      OP_POP_FRONT: begin
        if (was_empty) r.status = ST_EMPTY;
        else dq_head = wrap_next(dq_head, len);
      end
      OP_POP_BACK: begin
        if (was_empty) r.status = ST_EMPTY;
        else dq_tail = wrap_prev(dq_tail, len);
      end
      default: begin
      end
    endcase
    r.is_empty = (dq_head == dq_tail);
    r.is_full = deque_full();
    r.count = (dq_head <= dq_tail) ? CAP_W'(dq_tail - dq_head)
                                   : CAP_W'(dq_tail + len - dq_head);
    if (!r.is_empty) begin
      r.front = dq_store[dq_head];
      r.back = dq_store[wrap_prev(dq_tail, len)];
    end
    return r;
  endfunction

  function automatic logic [OP_W-1:0] pick_op(input traffic_mode_t mode);
    int r;
    int push_edge;
    int pop_edge;
    int sel;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL:  begin push_edge = 94; pop_edge = 98; end
      MODE_DRAIN: begin push_edge = 20; pop_edge = 88; end
      default:    begin push_edge = 45; pop_edge = 88; end
    endcase
    sel = $urandom_range(0, 3);
    if (r < push_edge) return sel[0] ? OP_PUSH_FRONT : OP_PUSH_BACK;
    if (r < pop_edge) return sel[0] ? OP_POP_FRONT : OP_POP_BACK;
    return (sel == 0) ? OP_PEEK : (sel == 1) ? OP_SPARE_A :
           (sel == 2) ? OP_SPARE_B : OP_SPARE_C;
  endfunction

  function automatic logic [DW-1:0] pick_value();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Offers one item and records what it should produce once it is taken.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [DW-1:0] value,
                           input bit pinned, input deq_result_t typed);
    deq_result_t predicted;
    if (src_idling && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= value;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predicted = deque_step(op, value);
    pend_results[pend_wr % PEND_DEPTH] = pinned ? typed : predicted;
    pend_wr++;
  endtask

  // The capacity may only change with nothing in flight, so drain first.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    s_axis_tvalid <= 1'b0;
    while (pend_wr != pend_rd) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    dq_cap = cap;
    dq_head = 0;
    dq_tail = 0;
  endtask

  // A fill phase runs until the deque has been full after eight of its items.
  task automatic run_phase(input traffic_mode_t mode, input int n_items);
    int sent;
    int full_hits;
    bit done;
    sent = 0;
    full_hits = 0;
    done = 1'b0;
    while (!done) begin
      send_item(pick_op(mode), pick_value(), 1'b0, PREDICTED);
      sent++;
      if (mode == MODE_FILL) begin
        if (deque_full()) full_hits++;
        done = (full_hits >= 8);
      end else begin
        done = (sent >= n_items);
      end
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= (stall_left == 1);
    end else if (sink_idling && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 10);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    deq_result_t got;
    deq_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      // Fields from the lowest bit up, as packed by the block.
      got.status   = m_axis_tdata[1:0];
      got.front    = m_axis_tdata[33:2];
      got.back     = m_axis_tdata[65:34];
      got.count    = m_axis_tdata[75:66];
      got.is_empty = m_axis_tdata[76];
      got.is_full  = m_axis_tdata[77];
      if (pend_wr == pend_rd) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d front %h back %h count %0d empty %b full %b",
                   got.status, got.front, got.back, got.count, got.is_empty, got.is_full);
      end else begin
        want = pend_results[pend_rd % PEND_DEPTH];
        pend_rd++;
        if (got.status !== want.status || got.front !== want.front ||
            got.back !== want.back || got.count !== want.count ||
            got.is_empty !== want.is_empty || got.is_full !== want.is_full) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected status %0d front %h back %h count %0d empty %b full %b",
                     want.status, want.front, want.back, want.count,
                     want.is_empty, want.is_full);
            $display("          got      status %0d front %h back %h count %0d empty %b full %b",
                     got.status, got.front, got.back, got.count, got.is_empty, got.is_full);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ring_buffer_double_ended_queue test failed");
      $finish;
    end
  end

  initial begin
    logic [CAP_W-1:0] cap;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    src_idling = 1'b1;
    sink_idling <= 1'b1;

    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].is_cfg) write_capacity(SCRIPT[i].value[CAP_W-1:0]);
      else send_item(SCRIPT[i].op, SCRIPT[i].value, SCRIPT[i].pinned, SCRIPT[i].want);
    end

    // Largest ring: fill it to the top, then let it drain a little.
    write_capacity(CAP_RESET);
    run_phase(MODE_FILL, 0);
    src_idling = 1'b1;
    sink_idling <= 1'b0;
    run_phase(MODE_DRAIN, 60);

    for (int k = 0; k < 10; k++) begin
      if (k < 3) cap = CAP_W'(k + 1);
      else if (k < 6) cap = CAP_W'($urandom_range(1, 8));
      else if (k < 9) cap = CAP_W'($urandom_range(9, 1023));
      else cap = CAP_RESET;
      write_capacity(cap);
      // The closing phases run with both sides at full rate.
      src_idling = (k < 7) ? bit'($urandom_range(0, 1)) : 1'b0;
      sink_idling <= (k < 7) ? bit'($urandom_range(0, 1)) : 1'b0;
      run_phase((k < 6 && k % 2 == 1) ? MODE_FILL : MODE_MIX, 25);
    end

    s_axis_tvalid <= 1'b0;
    while (pend_wr != pend_rd) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pend_wr == pend_rd) begin
      $display("ring_buffer_double_ended_queue test passed");
    end else begin
      $display("ring_buffer_double_ended_queue test failed");
    end
    $finish;
  end

endmodule
